// File: rtl/srat_pkg.sv
`default_nettype none

package srat_pkg;

    localparam int MAX_NODES_DEF   = 8;
    localparam int CHUNK_SHIFT_DEF = 26;
    localparam int APIC_SLOTS      = 256;

    // only the first 32 bytes of an entry are ever looked at
    localparam int ENTRY_KEEP = 32;
    localparam int KEEP_W     = $clog2(ENTRY_KEEP);

    localparam int               CC_W        = 25;
    localparam logic [CC_W-1:0]  CHUNK_LIMIT = 25'h100_0000;

    localparam logic [7:0] ENTRY_CPU    = 8'd0;
    localparam logic [7:0] ENTRY_MEM    = 8'd1;
    localparam logic [7:0] ENTRY_X2APIC = 8'd2;

    localparam logic [7:0] MIN_LEN_CPU    = 8'd16;
    localparam logic [7:0] MIN_LEN_MEM    = 8'd40;
    localparam logic [7:0] MIN_LEN_X2APIC = 8'd24;

    localparam logic REC_MEMORY = 1'b0;
    localparam logic REC_APIC   = 1'b1;

    typedef struct packed {
        logic [7:0] table_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic        record_kind;
        logic [2:0]  node_id;
        logic [37:0] first_chunk;
        logic [23:0] last_chunk;
        logic        range_empty;
        logic [7:0]  apic_id;
        logic [63:0] node_total_bytes;
        logic [3:0]  nodes_in_use;
    } t_out_item;

    typedef struct packed {
        logic accept;
        logic lookup;
        logic add;
        logic range;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic finish;
        logic want;
        logic found;
        logic is_mem;
        logic len_zero;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

// File: rtl/srat_ctrl.sv
`default_nettype none

module srat_ctrl
    import srat_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_stall,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_LOOKUP = 5'b00010,
        ST_ADD    = 5'b00100,
        ST_RANGE  = 5'b01000,
        ST_EMIT   = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
                if (i_in_valid && i_stat.finish) begin
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                if (!(i_stat.want && i_stat.found)) begin
                    n_state = ST_IDLE;
                end else if (i_stat.is_mem) begin
                    // zero-length range still claims a node, but emits nothing
                    n_state = i_stat.len_zero ? ST_IDLE : ST_ADD;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = ST_RANGE;
            end
            ST_RANGE: begin
                o_cmd.range = 1'b1;
                n_state     = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// File: rtl/srat_dp.sv
`default_nettype none

module srat_dp
    import srat_pkg::*;
#(
    parameter int MAX_NODES   = MAX_NODES_DEF,
    parameter int CHUNK_SHIFT = CHUNK_SHIFT_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire t_in_item        i_in,
    input  wire logic            i_cfg_valid,
    input  wire logic [CC_W-1:0] i_cfg_data,
    input  wire t_cmd            i_cmd,
    output t_stat                o_stat,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output t_out_item            o_out
);

    localparam int NODE_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CNT_W  = $clog2(MAX_NODES + 1);

    // parser state
    logic [7:0]      r_pos;
    logic [7:0]      r_len;
    logic            r_halted;
    logic [7:0]      r_bytes [ENTRY_KEEP];
    logic [CC_W-1:0] r_cc;

    // node table
    logic [MAX_NODES-1:0] r_used;
    logic [31:0]          r_domain     [MAX_NODES];
    logic [63:0]          r_node_bytes [MAX_NODES];

    // per-entry working registers
    logic [NODE_W-1:0] r_node;
    logic              r_kind;
    logic [7:0]        r_apic;
    logic [63:0]       r_len_m1;
    logic [63:0]       r_end;
    logic [63:0]       r_first;
    logic [63:0]       r_total;
    logic [23:0]       r_lastc;
    logic              r_empty;

    logic      r_out_valid;
    t_out_item r_out;

    // ---------------- byte parser ----------------
    logic [7:0] n_len;
    logic       len_short;
    logic       ends;

    always_comb begin
        n_len     = (r_pos == 8'd1) ? i_in.table_byte : r_len;
        len_short = (r_pos == 8'd1) && (i_in.table_byte < 8'd2);
        ends      = !r_halted && !len_short && (r_pos != 8'd0) &&
                    (({1'b0, r_pos} + 9'd1) == {1'b0, n_len});
    end

    // ---------------- entry decode ----------------
    logic [7:0]  ent_type;
    logic [31:0] mem_dom, cpu_dom, x2_dom, x2_id, dom;
    logic [63:0] base, len64;
    logic        mem_ok, cpu_ok, x2_ok, want;
    logic [7:0]  apic;

    always_comb begin
        ent_type = r_bytes[0];
        mem_dom  = {r_bytes[5], r_bytes[4], r_bytes[3], r_bytes[2]};
        cpu_dom  = {r_bytes[11], r_bytes[10], r_bytes[9], r_bytes[2]};
        x2_dom   = {r_bytes[7], r_bytes[6], r_bytes[5], r_bytes[4]};
        x2_id    = {r_bytes[11], r_bytes[10], r_bytes[9], r_bytes[8]};
        base     = {r_bytes[15], r_bytes[14], r_bytes[13], r_bytes[12],
                    r_bytes[11], r_bytes[10], r_bytes[9], r_bytes[8]};
        len64    = {r_bytes[23], r_bytes[22], r_bytes[21], r_bytes[20],
                    r_bytes[19], r_bytes[18], r_bytes[17], r_bytes[16]};

        mem_ok = (ent_type == ENTRY_MEM) && (r_len >= MIN_LEN_MEM) && r_bytes[28][0];
        cpu_ok = (ent_type == ENTRY_CPU) && (r_len >= MIN_LEN_CPU) && r_bytes[4][0];
        x2_ok  = (ent_type == ENTRY_X2APIC) && (r_len >= MIN_LEN_X2APIC) &&
                 r_bytes[12][0] && (x2_id < 32'(APIC_SLOTS));
        want   = mem_ok || cpu_ok || x2_ok;

        if (mem_ok) begin
            dom = mem_dom;
        end else if (cpu_ok) begin
            dom = cpu_dom;
        end else begin
            dom = x2_dom;
        end
        apic = cpu_ok ? r_bytes[3] : r_bytes[8];
    end

    // ---------------- domain lookup ----------------
    logic              hit, free;
    logic [NODE_W-1:0] hit_idx, free_idx, sel_idx;

    always_comb begin
        hit      = 1'b0;
        free     = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        // walk downward so the lowest index wins
        for (int i = MAX_NODES - 1; i >= 0; i--) begin
            if (r_used[i] && (r_domain[i] == dom)) begin
                hit     = 1'b1;
                hit_idx = NODE_W'(i);
            end
            if (!r_used[i]) begin
                free     = 1'b1;
                free_idx = NODE_W'(i);
            end
        end
        sel_idx = hit ? hit_idx : free_idx;
    end

    logic alloc;
    assign alloc = i_cmd.lookup && want && !hit && free;

    // ---------------- range math ----------------
    logic [CC_W-1:0] cc, cc_m1;
    logic [63:0]     lastc_raw;
    logic            empty;
    logic [23:0]     lastc_clip;

    always_comb begin
        cc         = r_cc[CC_W-1] ? CHUNK_LIMIT : r_cc;
        cc_m1      = cc - 1'b1;
        lastc_raw  = r_end >> CHUNK_SHIFT;
        empty      = (cc == '0) || (r_first > lastc_raw) ||
                     (r_first >= {{(64-CC_W){1'b0}}, cc});
        lastc_clip = (lastc_raw > {40'd0, cc_m1[23:0]}) ? cc_m1[23:0] : lastc_raw[23:0];
    end

    logic [63:0] node_sum;
    assign node_sum = r_node_bytes[r_node] + len64;

    logic [CNT_W-1:0] used_cnt;
    logic [3:0]       nodes_in_use;

    always_comb begin
        used_cnt = '0;
        for (int i = 0; i < MAX_NODES; i++) begin
            if (r_used[i]) begin
                used_cnt = CNT_W'(i + 1);
            end
        end
        nodes_in_use = (used_cnt == '0) ? 4'd1 : 4'(used_cnt);
    end

    // ---------------- registers with reset ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_len       <= '0;
            r_halted    <= 1'b0;
            r_cc        <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < MAX_NODES; i++) begin
                r_node_bytes[i] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_cc <= i_cfg_data;
            end
            if (i_cmd.accept) begin
                if (!r_halted) begin
                    if (r_pos == 8'd1) begin
                        r_len <= i_in.table_byte;
                    end
                    if (len_short) begin
                        r_halted <= 1'b1;
                        r_pos    <= '0;
                    end else if (ends) begin
                        r_pos <= '0;
                    end else begin
                        r_pos <= r_pos + 8'd1;
                    end
                end
                if (i_in.last_byte) begin
                    r_pos    <= '0;
                    r_halted <= 1'b0;
                end
            end
            if (alloc) begin
                r_used[sel_idx] <= 1'b1;
            end
            if (i_cmd.add) begin
                r_node_bytes[r_node] <= node_sum;
            end
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && !r_halted && (r_pos < 8'(ENTRY_KEEP))) begin
            r_bytes[r_pos[KEEP_W-1:0]] <= i_in.table_byte;
        end
        if (alloc) begin
            r_domain[sel_idx] <= dom;
        end
        if (i_cmd.lookup) begin
            r_node   <= sel_idx;
            r_kind   <= mem_ok ? REC_MEMORY : REC_APIC;
            r_apic   <= apic;
            r_len_m1 <= len64 - 64'd1;
        end
        if (i_cmd.add) begin
            r_total <= node_sum;
            r_end   <= base + r_len_m1;
            r_first <= base >> CHUNK_SHIFT;
        end
        if (i_cmd.range) begin
            r_empty <= empty;
            r_lastc <= empty ? 24'd0 : lastc_clip;
        end
        if (i_cmd.load) begin
            r_out.record_kind  <= r_kind;
            r_out.node_id      <= 3'(r_node);
            r_out.nodes_in_use <= nodes_in_use;
            if (r_kind == REC_MEMORY) begin
                r_out.first_chunk      <= r_first[37:0];
                r_out.last_chunk       <= r_lastc;
                r_out.range_empty      <= r_empty;
                r_out.apic_id          <= 8'd0;
                r_out.node_total_bytes <= r_total;
            end else begin
                r_out.first_chunk      <= '0;
                r_out.last_chunk       <= '0;
                r_out.range_empty      <= 1'b0;
                r_out.apic_id          <= r_apic;
                r_out.node_total_bytes <= r_node_bytes[r_node];
            end
        end
    end

    always_comb begin
        o_stat.finish   = ends;
        o_stat.want     = want;
        o_stat.found    = hit || free;
        o_stat.is_mem   = mem_ok;
        o_stat.len_zero = (len64 == 64'd0);
        o_stat.out_free = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

// File: rtl/srat_affinity_parser_core.sv
// Throughput: one table byte per cycle inside an entry; the byte closing an entry stalls
// the input for the lookup (no result), for lookup and output load (processor) or for
// lookup, byte-total add, chunk range and output load (memory), longer while a held output
// item waits. o_out_valid is registered and is set by the output load.
// Synchronous active-low reset clears the parser, node table, byte totals and chunk count.
`default_nettype none

module srat_affinity_parser_core
    import srat_pkg::*;
#(
    parameter int MAX_NODES   = MAX_NODES_DEF,
    parameter int CHUNK_SHIFT = CHUNK_SHIFT_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire t_in_item        i_in,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output t_out_item            o_out,
    input  wire logic            i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire logic [CC_W-1:0] i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    srat_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    srat_dp #(
        .MAX_NODES   (MAX_NODES),
        .CHUNK_SHIFT (CHUNK_SHIFT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

// File: sim/srat_affinity_parser_core_tb.sv
`timescale 1ns / 1ps

module srat_affinity_parser_core_tb
    import srat_pkg::*;
;

    localparam int NODES      = MAX_NODES_DEF;
    localparam int SHIFT      = CHUNK_SHIFT_DEF;
    localparam int KEEP       = 40;
    localparam int NPHASE     = 6;
    localparam int PHASE_BYTES = 100;
    localparam int LIMIT      = 500000;
    localparam int SETTLE     = 12;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_in_valid;
    logic            o_in_stall;
    t_in_item        i_in;
    logic            o_out_valid;
    logic            i_out_stall;
    t_out_item       o_out;
    logic            i_cfg_valid;
    logic            o_cfg_ready;
    logic [CC_W-1:0] i_cfg_data;

    srat_affinity_parser_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // shadow of the parser state
    logic [CC_W-1:0] chunk_cnt;
    int unsigned     ent_pos;
    int unsigned     ent_len;
    logic [7:0]      ent_buf [0:KEEP-1];
    bit              halted;
    bit              dom_used [0:NODES-1];
    logic [31:0]     dom_val [0:NODES-1];
    logic [63:0]     dom_bytes [0:NODES-1];

    t_out_item   want_records [$];
    t_in_item    pending [$];
    logic [7:0]  tbl_bytes [$];
    logic [31:0] dom_pool [0:7];

    int  queued;
    int  last_elen;
    int  mismatches;
    int  cycle_cnt;
    int  in_idle_pct;
    int  out_stall_pct;
    bit  rst_done;
    bit  in_taken;

    function automatic logic [31:0] ent_le32(input int off);
        return {ent_buf[off+3], ent_buf[off+2], ent_buf[off+1], ent_buf[off]};
    endfunction

    function automatic int assign_node(input logic [31:0] dom);
        for (int i = 0; i < NODES; i++)
            if (dom_used[i] && dom_val[i] == dom)
                return i;
        for (int i = 0; i < NODES; i++)
            if (!dom_used[i]) begin
                dom_used[i] = 1'b1;
                dom_val[i]  = dom;
                return i;
            end
        return -1;
    endfunction

    function automatic logic [3:0] nodes_active();
        logic [3:0] n;
        n = 4'd1;
        for (int i = 0; i < NODES; i++)
            if (dom_used[i])
                n = 4'(i + 1);
        return n;
    endfunction

    task automatic close_entry();
        t_out_item   rec;
        logic [63:0] base, len, first, lastc, cc;
        logic [31:0] flags, id;
        int          node;
        bit          hit;
        rec  = '0;
        node = -1;
        hit  = 1'b0;
        if (ent_buf[0] == ENTRY_MEM && ent_len >= MIN_LEN_MEM) begin
            flags = ent_le32(28);
            if (flags[0]) begin
                base = {ent_le32(12), ent_le32(8)};
                len  = {ent_le32(20), ent_le32(16)};
                node = assign_node(ent_le32(2));
                if (node >= 0 && len != 64'd0) begin
                    dom_bytes[node] += len;
                    first = base >> SHIFT;
                    lastc = (base + len - 64'd1) >> SHIFT;
                    cc = (chunk_cnt > CHUNK_LIMIT) ? 64'(CHUNK_LIMIT) : 64'(chunk_cnt);
                    rec.record_kind = REC_MEMORY;
                    rec.first_chunk = first[37:0];
                    if (cc == 64'd0 || first > lastc || first >= cc) begin
                        rec.range_empty = 1'b1;
                    end else begin
                        if (lastc > cc - 64'd1)
                            lastc = cc - 64'd1;
                        rec.last_chunk = lastc[23:0];
                    end
                    hit = 1'b1;
                end
            end
        end else if (ent_buf[0] == ENTRY_CPU && ent_len >= MIN_LEN_CPU) begin
            flags = ent_le32(4);
            if (flags[0]) begin
                node = assign_node({ent_buf[11], ent_buf[10], ent_buf[9], ent_buf[2]});
                if (node >= 0) begin
                    rec.record_kind = REC_APIC;
                    rec.apic_id     = ent_buf[3];
                    hit = 1'b1;
                end
            end
        end else if (ent_buf[0] == ENTRY_X2APIC && ent_len >= MIN_LEN_X2APIC) begin
            flags = ent_le32(12);
            id    = ent_le32(8);
            if (flags[0] && id < APIC_SLOTS) begin
                node = assign_node(ent_le32(4));
                if (node >= 0) begin
                    rec.record_kind = REC_APIC;
                    rec.apic_id     = id[7:0];
                    hit = 1'b1;
                end
            end
        end
        if (hit) begin
            rec.node_id          = node[2:0];
            rec.node_total_bytes = dom_bytes[node];
            rec.nodes_in_use     = nodes_active();
            want_records.push_back(rec);
        end
    endtask

    task automatic parse_table_byte(input t_in_item it);
        if (!halted) begin
            if (ent_pos < KEEP)
                ent_buf[ent_pos] = it.table_byte;
            if (ent_pos == 1)
                ent_len = it.table_byte;
            if (ent_pos == 1 && it.table_byte < 8'd2) begin
                halted  = 1'b1;
                ent_pos = 0;
            end else if (ent_pos >= 1 && ent_pos + 1 == ent_len) begin
                close_entry();
                ent_pos = 0;
            end else begin
                ent_pos = (ent_pos + 1) & 32'hFF;
            end
        end
        if (it.last_byte) begin
            ent_pos = 0;
            halted  = 1'b0;
        end
    endtask

    // entry builder: p0 is apic id / x2apic id / base, p1 is the memory length
    task automatic make_entry(input logic [7:0] etype, input int elen, input logic [31:0] dom,
                              input logic [63:0] p0, input logic [63:0] p1, input bit en);
        logic [7:0]  e [0:255];
        logic [31:0] flags;
        for (int i = 0; i < 256; i++)
            e[i] = 8'($urandom);
        flags    = $urandom;
        flags[0] = en;
        e[0] = etype;
        e[1] = elen[7:0];
        case (etype)
            ENTRY_CPU: begin
                e[2] = dom[7:0];
                e[3] = p0[7:0];
                {e[7], e[6], e[5], e[4]} = flags;
                {e[11], e[10], e[9]} = dom[31:8];
            end
            ENTRY_MEM: begin
                {e[5], e[4], e[3], e[2]} = dom;
                {e[15], e[14], e[13], e[12], e[11], e[10], e[9], e[8]} = p0;
                {e[23], e[22], e[21], e[20], e[19], e[18], e[17], e[16]} = p1;
                {e[31], e[30], e[29], e[28]} = flags;
            end
            ENTRY_X2APIC: begin
                {e[7], e[6], e[5], e[4]} = dom;
                {e[11], e[10], e[9], e[8]} = p0[31:0];
                {e[15], e[14], e[13], e[12]} = flags;
            end
            default: ;
        endcase
        for (int i = 0; i < elen; i++)
            tbl_bytes.push_back(e[i]);
        last_elen = elen;
    endtask

    // length byte below two, then bytes the block has to ignore
    task automatic push_halt(input logic [7:0] lenb);
        tbl_bytes.push_back(8'($urandom));
        tbl_bytes.push_back(lenb);
        repeat ($urandom_range(0, 6))
            tbl_bytes.push_back(8'($urandom));
    endtask

    task automatic close_table();
        t_in_item it;
        foreach (tbl_bytes[i]) begin
            it.table_byte = tbl_bytes[i];
            it.last_byte  = (i == tbl_bytes.size() - 1);
            pending.push_back(it);
        end
        queued += tbl_bytes.size();
        tbl_bytes.delete();
    endtask

    task automatic rand_mem(output logic [63:0] base, output logic [63:0] len);
        int unsigned span;
        span = chunk_cnt + 3;
        case ($urandom_range(0, 6))
            0, 1, 2: begin
                base = (64'($urandom_range(0, span)) << SHIFT) |
                       64'($urandom_range(0, (1 << SHIFT) - 1));
                len  = (64'($urandom_range(0, 6)) << SHIFT) + 64'($urandom);
            end
            3: begin
                base = {$urandom, $urandom};
                len  = {$urandom, $urandom};
            end
            4: begin
                // close to the top of the address space, usually wraps
                base = ~64'($urandom_range(0, 1 << 28));
                len  = 64'($urandom_range(1, 1 << 30));
            end
            5: begin
                base = 64'($urandom);
                len  = {$urandom, $urandom} >> $urandom_range(0, 63);
            end
            default: begin
                // start right at the end of the table
                base = 64'(chunk_cnt - $urandom_range(0, 1)) << SHIFT;
                len  = 64'($urandom_range(1, 3)) << SHIFT;
            end
        endcase
        if ($urandom_range(0, 19) == 0)
            len = 64'd0;
    endtask

    task automatic rand_entry();
        int          pick, elen, min_len;
        logic [31:0] dom;
        logic [63:0] p0, p1;
        logic [7:0]  et;
        bit          en;
        pick = $urandom_range(0, 99);
        dom  = ($urandom_range(0, 99) < 85) ? dom_pool[$urandom_range(0, 7)] : $urandom;
        en   = ($urandom_range(0, 9) != 0);
        p0   = {$urandom, $urandom};
        p1   = {$urandom, $urandom};
        if (pick < 40) begin
            et   = ENTRY_MEM;
            elen = MIN_LEN_MEM;
            rand_mem(p0, p1);
        end else if (pick < 65) begin
            et   = ENTRY_CPU;
            elen = MIN_LEN_CPU;
        end else if (pick < 85) begin
            et   = ENTRY_X2APIC;
            elen = MIN_LEN_X2APIC;
            case ($urandom_range(0, 7))
                0:       p0 = {32'h0, $urandom};
                1:       p0 = 64'd256;
                default: p0 = 64'($urandom_range(0, 255));
            endcase
        end else if (pick < 90) begin
            et   = 8'($urandom_range(3, 255));
            elen = $urandom_range(2, 48);
        end else begin
            et      = 8'($urandom_range(0, 2));
            min_len = (et == ENTRY_CPU) ? MIN_LEN_CPU :
                      (et == ENTRY_MEM) ? MIN_LEN_MEM : MIN_LEN_X2APIC;
            elen    = $urandom_range(2, min_len - 1);
        end
        if (pick < 85 && $urandom_range(0, 9) == 0)
            elen = $urandom_range(elen, 255);
        make_entry(et, elen, dom, p0, p1, en);
    endtask

    task automatic rand_table();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) begin
            tbl_bytes.push_back(8'($urandom));
        end else begin
            repeat ($urandom_range(1, 5))
                rand_entry();
            if (r < 9) begin
                push_halt(8'($urandom_range(0, 1)));
            end else if (r < 15) begin
                // table ends inside an entry
                rand_entry();
                repeat ($urandom_range(1, last_elen - 1))
                    void'(tbl_bytes.pop_back());
            end
        end
        close_table();
    endtask

    task automatic drain();
        while (pending.size() != 0 || want_records.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_chunk_count(input logic [CC_W-1:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        chunk_cnt = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic directed_tables();
        // processor entries at the id extremes, one disabled
        make_entry(ENTRY_CPU, 16, 32'h0, 64'd0, 64'd0, 1'b1);
        make_entry(ENTRY_CPU, 16, 32'hFFFF_FFFF, 64'd255, 64'd0, 1'b1);
        make_entry(ENTRY_CPU, 16, 32'd5, 64'd7, 64'd0, 1'b0);
        make_entry(ENTRY_X2APIC, 24, 32'h0, 64'd255, 64'd0, 1'b1);
        make_entry(ENTRY_X2APIC, 24, 32'h0, 64'd256, 64'd0, 1'b1);
        make_entry(ENTRY_X2APIC, 24, 32'h0, 64'hFFFF_FFFF, 64'd0, 1'b1);
        // memory: one byte, zero length, wrapping, clipped, past the table, disabled
        make_entry(ENTRY_MEM, 40, 32'h0, 64'd0, 64'd1, 1'b1);
        make_entry(ENTRY_MEM, 40, 32'd77, 64'h4000_0000, 64'd0, 1'b1);
        make_entry(ENTRY_MEM, 40, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd2, 1'b1);
        make_entry(ENTRY_MEM, 40, 32'hFFFF_FFFF, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
        make_entry(ENTRY_MEM, 40, 32'hFFFF_FFFF, 64'd64 << SHIFT, 64'd1 << SHIFT, 1'b1);
        make_entry(ENTRY_MEM, 40, 32'h0, 64'd0, 64'h100, 1'b0);
        // one byte short of the minimum, unknown types, long entry
        make_entry(ENTRY_MEM, 39, 32'h0, 64'd0, 64'h100, 1'b1);
        make_entry(ENTRY_CPU, 15, 32'h0, 64'd1, 64'd0, 1'b1);
        make_entry(ENTRY_X2APIC, 23, 32'h0, 64'd1, 64'd0, 1'b1);
        make_entry(8'd3, 20, 32'h0, 64'd0, 64'd0, 1'b1);
        make_entry(8'hFF, 2, 32'h0, 64'd0, 64'd0, 1'b1);
        make_entry(ENTRY_MEM, 255, 32'd77, 64'd3 << SHIFT, 64'd5 << SHIFT, 1'b1);
        close_table();

        make_entry(ENTRY_CPU, 16, 32'd77, 64'd9, 64'd0, 1'b1);
        push_halt(8'd0);
        close_table();
        push_halt(8'd1);
        close_table();

        // fill the node table, then one domain too many
        for (int d = 100; d <= 105; d++)
            make_entry(ENTRY_CPU, 16, d, 64'(d), 64'd0, 1'b1);
        make_entry(ENTRY_MEM, 40, 32'd104, 64'd10 << SHIFT, 64'd100 << SHIFT, 1'b1);
        close_table();

        make_entry(ENTRY_MEM, 40, 32'h0, 64'd0, 64'd1, 1'b1);
        repeat (10) void'(tbl_bytes.pop_back());
        close_table();
        tbl_bytes.push_back(8'hA5);
        close_table();
    endtask

    // input side: acceptance at the rising edge, next item at the falling edge
    always @(posedge i_clk) begin
        in_taken = 1'b0;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            parse_table_byte(i_in);
            void'(pending.pop_front());
            in_taken = 1'b1;
        end
    end

    always @(negedge i_clk) begin
        if (rst_done && (!i_in_valid || in_taken)) begin
            if (pending.size() != 0 && $urandom_range(0, 99) >= in_idle_pct) begin
                i_in_valid <= 1'b1;
                i_in       <= pending[0];
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result side
    always @(posedge i_clk) begin
        t_out_item due;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (want_records.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item at cycle %0d", cycle_cnt);
            end else begin
                due = want_records.pop_front();
                if (o_out !== due) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch at cycle %0d", cycle_cnt);
                        $display({"  exp kind=%0d node=%0d first=%h last=%h empty=%0d",
                                  " apic=%0d total=%h nodes=%0d"},
                                 due.record_kind, due.node_id, due.first_chunk, due.last_chunk,
                                 due.range_empty, due.apic_id, due.node_total_bytes,
                                 due.nodes_in_use);
                        $display({"  got kind=%0d node=%0d first=%h last=%h empty=%0d",
                                  " apic=%0d total=%h nodes=%0d"},
                                 o_out.record_kind, o_out.node_id, o_out.first_chunk,
                                 o_out.last_chunk, o_out.range_empty, o_out.apic_id,
                                 o_out.node_total_bytes, o_out.nodes_in_use);
                    end
                end
            end
        end
    end

    always @(negedge i_clk)
        i_out_stall <= rst_done && ($urandom_range(0, 99) < out_stall_pct);

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        logic [CC_W-1:0] cc_set [0:NPHASE-1];
        int              idle_set [0:NPHASE-1];
        int              stall_set [0:NPHASE-1];
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in          = '0;
        i_out_stall   = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        cycle_cnt     = 0;
        mismatches    = 0;
        queued        = 0;
        in_idle_pct   = 0;
        out_stall_pct = 0;
        rst_done      = 1'b0;
        in_taken      = 1'b0;
        chunk_cnt     = '0;
        ent_pos       = 0;
        ent_len       = 0;
        halted        = 1'b0;
        for (int i = 0; i < NODES; i++) begin
            dom_used[i]  = 1'b0;
            dom_bytes[i] = 64'd0;
        end
        dom_pool  = '{32'h0, 32'hFFFF_FFFF, 32'd77, 32'd100, 32'd101, 32'd102, 32'd103, 32'd104};
        cc_set    = '{25'd0, 25'd1, CHUNK_LIMIT, 25'h1FF_FFFF, 25'h0FF_FFFF,
                      25'($urandom_range(2, 4096))};
        idle_set  = '{0, 82, 0, 35, 0, 82};
        stall_set = '{0, 0, 82, 35, 0, 82};

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        rst_done = 1'b1;

        write_chunk_count(25'd64);
        directed_tables();
        drain();

        for (int p = 0; p < NPHASE; p++) begin
            write_chunk_count(cc_set[p]);
            in_idle_pct   = idle_set[p];
            out_stall_pct = stall_set[p];
            queued = 0;
            while (queued < PHASE_BYTES / 2)
                rand_table();
            // sender holds off until every result is out
            drain();
            while (queued < PHASE_BYTES)
                rand_table();
            drain();
        end

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
